### rtl/hmti_pkg.sv
// shared types and constants of the heightmap triangle interpolator
// used by every module of the block but hmti_ram, depends on nothing

package hmti_pkg;

    localparam int ADDR_W       = 17;
    localparam int OFS_W        = 11;
    localparam int POS_W        = 12;
    localparam int PROD_W       = 30;
    localparam int HEIGHT_W     = 16;
    localparam int HEIGHT_SCALE = 10;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                      is_query;
        logic                      outside;
        logic [ADDR_W-1:0]         addr0;
        logic [ADDR_W-1:0]         addr1;
        logic [ADDR_W-1:0]         addr2;
        logic signed [HEIGHT_W-1:0] wr_value;
        logic [OFS_W-1:0]          u;
        logic [OFS_W-1:0]          w;
    } hmti_entry_t;

endpackage

### rtl/heightmap_triangle_interpolator.sv
// top level of the heightmap triangle interpolator
// depends on hmti_pkg, hmti_front, hmti_back, hmti_ram and hmti_div
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser action, tdata vertex and position fields
// m_       out  m_tvalid/m_tready  tdata height_out
// cfg_     in   cfg_wr_en          cfg_wr_data diagonal_parity
//
// a write is accepted every cycle while the queue has room and is written to the ram when it
// reaches the queue head with the back end idle; a query holds s_tready low through the tile
// split and queue push states, then the back end does three registered ram reads, two
// reciprocal divisions by the tile size and a bit-serial division by the remaining span; the
// divisions are skipped when w reaches the tile size; a stalled m_tready holds the back end.
// reset clears control state and parity; vertex heights are undefined until written.
// a two-entry queue lets the front end keep accepting while the output stalls.

module heightmap_triangle_interpolator import hmti_pkg::*; #(
    parameter int GRID_TILES = 32,
    parameter int TILE_UNITS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex_x[5:0], vertex_z[11:6], write_height[24:12], pos_x[36:25], pos_z[48:37]
    input  logic [55:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // height_out[15:0]
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    localparam int VERTS  = GRID_TILES + 1;
    localparam int DEPTH  = VERTS * VERTS;
    localparam int RAM_AW = $clog2(DEPTH);

    logic                parity_reg;
    logic                not_empty, pop;
    hmti_entry_t         head;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            parity_reg <= cfg_wr_data;
        end
    end

    hmti_front #(
        .GRID_TILES (GRID_TILES),
        .TILE_UNITS (TILE_UNITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .parity    (parity_reg),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    hmti_back #(
        .TILE_UNITS (TILE_UNITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    hmti_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr[RAM_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

endmodule

### rtl/hmti_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module hmti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1089
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/hmti_div.sv
// bit-serial signed divider, truncates toward zero, positive divisor
// depends on hmti_pkg

module hmti_div import hmti_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [PROD_W-1:0] num,
    input  logic [OFS_W-1:0]         den,
    output logic                     done,
    output logic signed [PROD_W-1:0] quo
);

    localparam int CW = $clog2(PROD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PROD_W-1:0] mag_reg, mag_next;
    logic [OFS_W:0]    rem_reg, rem_next;
    logic [OFS_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [OFS_W:0]    r;
    logic              ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        r  = {rem_reg[OFS_W-1:0], mag_reg[PROD_W-1]};
        ge = (r >= {1'b0, den_reg});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[PROD_W-1];
            mag_next  = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            mag_next = {mag_reg[PROD_W-2:0], ge};
            rem_next = ge ? (r - {1'b0, den_reg}) : r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(PROD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

### rtl/hmti_front.sv
// front end: accepts transactions, splits query positions into tile and offset,
// picks the triangle and queues work for the back end; depends on hmti_pkg

module hmti_front import hmti_pkg::*; #(
    parameter int GRID_TILES = 32,
    parameter int TILE_UNITS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        parity,
    input  logic        pop,
    output logic        not_empty,
    output hmti_entry_t head
);

    localparam int VERTS = GRID_TILES + 1;
    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;
    localparam logic [OFS_W-1:0] T_OFS = OFS_W'(TILE_UNITS);
    // reciprocal of the tile size, exact for every 12-bit position
    localparam int     TW = $clog2(TILE_UNITS);
    localparam int     RK = POS_W + TW;
    localparam int     PW = 2 * POS_W + 1;
    localparam longint RM = ((longint'(1) << RK) + longint'(TILE_UNITS) - 1)
                            / longint'(TILE_UNITS);

    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] qx_reg, qx_next, qz_reg, qz_next;
    logic [OFS_W-1:0] rx_reg, rx_next, rz_reg, rz_next;

    hmti_entry_t q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        full, push;
    hmti_entry_t push_entry;

    logic [5:0]                 vx, vz;
    logic signed [12:0]         wh;
    logic signed [16:0]         wprod;
    logic signed [HEIGHT_W-1:0] wsat;
    logic                       wr_ok;
    logic [PW-1:0]              px_prod, pz_prod;
    logic [POS_W-1:0]           tix, tiz;
    logic [OFS_W-1:0]           ofx, ofz;
    logic                       outside;
    logic [ADDR_W-1:0]          base;
    logic [OFS_W-1:0]           tmox, tmoz;

    assign vx = s_tdata[5:0];
    assign vz = s_tdata[11:6];
    assign wh = $signed(s_tdata[24:12]);
    assign wprod = 17'(wh) * 17'sd10;
    assign wsat = (wprod > 17'sd32767) ? 16'sh7fff :
                  (wprod < -17'sd32768) ? 16'sh8000 : HEIGHT_W'(wprod);
    assign wr_ok = (int'(vx) <= GRID_TILES) && (int'(vz) <= GRID_TILES);

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = q_reg[rd_ptr_reg];

    assign px_prod = PW'(qx_reg) * PW'(RM);
    assign pz_prod = PW'(qz_reg) * PW'(RM);
    assign tix = POS_W'(px_prod >> RK);
    assign tiz = POS_W'(pz_prod >> RK);
    assign ofx = OFS_W'(qx_reg - POS_W'(int'(tix) * TILE_UNITS));
    assign ofz = OFS_W'(qz_reg - POS_W'(int'(tiz) * TILE_UNITS));

    assign outside = (int'(qx_reg) >= GRID_TILES) || (int'(qz_reg) >= GRID_TILES);
    assign base = outside ? '0 : ADDR_W'(int'(qx_reg) * VERTS + int'(qz_reg));
    assign tmox = T_OFS - rx_reg;
    assign tmoz = T_OFS - rz_reg;

    always_comb begin
        state_next = state_reg;
        qx_next    = qx_reg;
        qz_next    = qz_reg;
        rx_next    = rx_reg;
        rz_next    = rz_reg;
        s_tready   = 1'b0;
        push       = 1'b0;
        push_entry = '0;
        case (state_reg)
            FS_IDLE: begin
                s_tready = !full;
                if (s_tvalid && !full) begin
                    if (s_tuser == ACT_WRITE) begin
                        push = wr_ok;
                        push_entry.addr0 = ADDR_W'(int'(vx) * VERTS + int'(vz));
                        push_entry.wr_value = wsat;
                    end else begin
                        qx_next    = s_tdata[36:25];
                        qz_next    = s_tdata[48:37];
                        rx_next    = '0;
                        rz_next    = '0;
                        state_next = FS_DIV;
                    end
                end
            end
            FS_DIV: begin
                qx_next    = tix;
                qz_next    = tiz;
                rx_next    = ofx;
                rz_next    = ofz;
                state_next = FS_PUSH;
            end
            FS_PUSH: begin
                push_entry.is_query = 1'b1;
                push_entry.outside  = outside;
                if (parity) begin
                    push_entry.addr1 = base + ADDR_W'(1);
                    push_entry.addr2 = base + ADDR_W'(VERTS);
                    if (tmox > rz_reg) begin
                        push_entry.addr0 = base;
                        push_entry.u = rx_reg;
                        push_entry.w = rz_reg;
                    end else begin
                        push_entry.addr0 = base + ADDR_W'(VERTS + 1);
                        push_entry.u = tmoz;
                        push_entry.w = tmox;
                    end
                end else begin
                    push_entry.addr1 = base;
                    push_entry.addr2 = base + ADDR_W'(VERTS + 1);
                    if (rx_reg < rz_reg) begin
                        push_entry.addr0 = base + ADDR_W'(1);
                        push_entry.u = rx_reg;
                        push_entry.w = tmoz;
                    end else begin
                        push_entry.addr0 = base + ADDR_W'(VERTS);
                        push_entry.u = rz_reg;
                        push_entry.w = tmox;
                    end
                end
                if (!full) begin
                    push       = 1'b1;
                    state_next = FS_IDLE;
                end
            end
            default: begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FS_IDLE;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
        qx_reg  <= qx_next;
        qz_reg  <= qz_next;
        rx_reg  <= rx_next;
        rz_reg  <= rz_next;
    end

endmodule

### rtl/hmti_back.sv
// back end: performs height writes, reads three corners and blends them
// depends on hmti_pkg and hmti_div

module hmti_back import hmti_pkg::*; #(
    parameter int TILE_UNITS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                not_empty,
    input  hmti_entry_t         head,
    output logic                pop,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [HEIGHT_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  logic [HEIGHT_W-1:0] ram_rdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RC   = 4'd2;
    localparam logic [3:0] S_D1S  = 4'd3;
    localparam logic [3:0] S_D1W  = 4'd4;
    localparam logic [3:0] S_D2S  = 4'd5;
    localparam logic [3:0] S_D2W  = 4'd6;
    localparam logic [3:0] S_D3S  = 4'd7;
    localparam logic [3:0] S_D3W  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [OFS_W-1:0] T_OFS = OFS_W'(TILE_UNITS);
    // reciprocal of the tile size, exact for every edge product magnitude
    localparam int     TW    = $clog2(TILE_UNITS);
    localparam int     MAG_W = HEIGHT_W + OFS_W - 1;
    localparam int     RK    = MAG_W + TW;
    localparam int     RP_W  = 2 * MAG_W + 1;
    localparam longint RM    = ((longint'(1) << RK) + longint'(TILE_UNITS) - 1)
                               / longint'(TILE_UNITS);

    logic [3:0]  state_reg, state_next;
    logic [1:0]  k_reg, k_next;
    hmti_entry_t e_reg, e_next;
    logic signed [HEIGHT_W-1:0] a_reg [3];
    logic signed [HEIGHT_W-1:0] a_next [3];
    logic signed [17:0] h1_reg, h1_next, h2_reg, h2_next;
    logic signed [HEIGHT_W-1:0] res_reg, res_next;
    logic        ov_reg, ov_next;
    logic [15:0] od_reg, od_next;
    logic [MAG_W-1:0] cmag_reg, cmag_next;
    logic             cneg_reg, cneg_next;

    logic                     div_start, div_done;
    logic signed [PROD_W-1:0] div_num, div_quo;
    logic [OFS_W-1:0]         div_den;
    logic signed [PROD_W-1:0] diff, fac, sum;
    logic [RP_W-1:0]          rprod;
    logic [MAG_W-1:0]         cq;
    logic signed [PROD_W-1:0] cquo;

    hmti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        case (k_reg)
            2'd0:    ram_raddr = e_reg.addr0;
            2'd1:    ram_raddr = e_reg.addr1;
            default: ram_raddr = e_reg.addr2;
        endcase
    end

    assign ram_waddr = head.addr0;
    assign ram_wdata = head.wr_value;

    always_comb begin
        case (state_reg)
            S_D1S:   diff = PROD_W'(a_reg[1]) - PROD_W'(a_reg[0]);
            S_D2S:   diff = PROD_W'(a_reg[1]) - PROD_W'(a_reg[2]);
            default: diff = PROD_W'(h2_reg) - PROD_W'(h1_reg);
        endcase
        fac     = (state_reg == S_D3S) ? $signed(PROD_W'(e_reg.u)) : $signed(PROD_W'(e_reg.w));
        div_num = diff * fac;
        div_den = (state_reg == S_D3S) ? (T_OFS - e_reg.w) : T_OFS;
    end

    assign sum = div_quo + PROD_W'(h1_reg);

    assign rprod = RP_W'(cmag_reg) * RP_W'(RM);
    assign cq    = MAG_W'(rprod >> RK);
    assign cquo  = cneg_reg ? -$signed(PROD_W'(cq)) : $signed(PROD_W'(cq));

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        a_next     = a_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        cmag_next  = cmag_reg;
        cneg_next  = cneg_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (not_empty) begin
                    pop = 1'b1;
                    if (!head.is_query) begin
                        ram_we = 1'b1;
                    end else begin
                        e_next     = head;
                        k_next     = 2'd0;
                        state_next = S_RA;
                    end
                end
            end
            S_RA: begin
                state_next = S_RC;
            end
            S_RC: begin
                a_next[k_reg] = e_reg.outside ? '0 : $signed(ram_rdata);
                if (k_reg == 2'd2) begin
                    if (e_reg.w >= T_OFS) begin
                        res_next   = a_reg[1];
                        state_next = S_OUT;
                    end else begin
                        state_next = S_D1S;
                    end
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RA;
                end
            end
            S_D1S: begin
                cneg_next  = div_num[PROD_W-1];
                cmag_next  = MAG_W'(div_num[PROD_W-1] ? -div_num : div_num);
                state_next = S_D1W;
            end
            S_D1W: begin
                h1_next    = 18'(cquo + PROD_W'(a_reg[0]));
                state_next = S_D2S;
            end
            S_D2S: begin
                cneg_next  = div_num[PROD_W-1];
                cmag_next  = MAG_W'(div_num[PROD_W-1] ? -div_num : div_num);
                state_next = S_D2W;
            end
            S_D2W: begin
                h2_next    = 18'(cquo + PROD_W'(a_reg[2]));
                state_next = S_D3S;
            end
            S_D3S: begin
                div_start  = 1'b1;
                state_next = S_D3W;
            end
            S_D3W: begin
                if (div_done) begin
                    if (sum > PROD_W'(32767)) begin
                        res_next = 16'sh7fff;
                    end else if (sum < -PROD_W'(32768)) begin
                        res_next = 16'sh8000;
                    end else begin
                        res_next = HEIGHT_W'(sum);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    od_next    = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        k_reg    <= k_next;
        e_reg    <= e_next;
        a_reg    <= a_next;
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        res_reg  <= res_next;
        od_reg   <= od_next;
        cmag_reg <= cmag_next;
        cneg_reg <= cneg_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

endmodule
